/* rtl/lfu_pkg.sv */
`default_nettype none

package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 5;
  localparam int CAP_RESET  = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W     = IDX_W;
  localparam int OCC_W      = $clog2(ENTRIES + 1);
  localparam int CMP_W      = (CAP_W > OCC_W) ? CAP_W : OCC_W;

  typedef enum logic [2:0] {
    OP_IDLE   = 3'd0,
    OP_TOUCH  = 3'd1,
    OP_EVICT  = 3'd2,
    OP_INSERT = 3'd3,
    OP_SCAN   = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic              wr_value;
    logic [RANK_W-1:0] ref_rank;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } cell_cmd_t;

  // best eviction candidate seen so far along the chain
  typedef struct packed {
    logic                  found;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_W-1:0]     rank;
    logic [IDX_W-1:0]      idx;
  } cand_t;

endpackage

`default_nettype wire

/* rtl/lfu_cell.sv */
`default_nettype none

module lfu_cell (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire  [lfu_pkg::IDX_W-1:0] idx_i,
  input  wire  lfu_pkg::cell_cmd_t  cmd_i,
  input  wire                       sel_i,
  input  wire  lfu_pkg::cand_t      cand_i,
  output lfu_pkg::cand_t            cand_o,
  output logic                      valid_o,
  output logic                      match_o,
  output logic [lfu_pkg::VAL_W-1:0] value_o,
  output logic [lfu_pkg::RANK_W-1:0] rank_o
);
  import lfu_pkg::*;

  logic                  valid_q;
  logic [KEY_W-1:0]      key_q;
  logic [VAL_W-1:0]      value_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [RANK_W-1:0]     rank_q;
  cand_t                 cand_q;
  cand_t                 cand_d;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  own_better;

  assign count_inc = (count_q == {COUNT_BITS{1'b1}}) ? count_q : count_q + 1'b1;

  assign own_better = valid_q &&
                      (!cand_i.found || (count_q < cand_i.count) ||
                       ((count_q == cand_i.count) && (rank_q > cand_i.rank)));

  always_comb begin
    cand_d = cand_i;
    if (own_better) begin
      cand_d.found = 1'b1;
      cand_d.count = count_q;
      cand_d.rank  = rank_q;
      cand_d.idx   = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      if (sel_i && (cmd_i.op == OP_EVICT)) begin
        valid_q <= 1'b0;
      end else if (sel_i && (cmd_i.op == OP_INSERT)) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_TOUCH: begin
        if (sel_i) begin
          rank_q  <= '0;
          count_q <= count_inc;
          if (cmd_i.wr_value) begin
            value_q <= cmd_i.value;
          end
        end else if (valid_q && (rank_q < cmd_i.ref_rank)) begin
          rank_q <= rank_q + 1'b1;
        end
      end
      OP_EVICT: begin
        if (!sel_i && valid_q && (rank_q > cmd_i.ref_rank)) begin
          rank_q <= rank_q - 1'b1;
        end
      end
      OP_INSERT: begin
        if (sel_i) begin
          key_q   <= cmd_i.key;
          value_q <= cmd_i.value;
          count_q <= COUNT_BITS'(1);
          rank_q  <= '0;
        end else if (valid_q) begin
          rank_q <= rank_q + 1'b1;
        end
      end
      OP_SCAN: begin
        cand_q <= cand_d;
      end
      default: begin
      end
    endcase
  end

  assign cand_o  = cand_q;
  assign valid_o = valid_q;
  assign match_o = valid_q && (key_q == cmd_i.key);
  assign value_o = value_q;
  assign rank_o  = rank_q;

endmodule

`default_nettype wire

/* rtl/lfu_cache_table_core.sv */
// LFU cache, LRU order among equal counts, held in a row of entry cells.
// A get, a put hit, or a put with a free slot runs the match step, then the
// insert step for a fresh put, then done; each eviction first adds a scan (the
// victim candidate walks the cell chain one cell per cycle) and an evict step.
// One item in flight; the next input is taken when the block is idle.
// Reset clears valid marks, occupancy and handshakes; capacity resets to 16.
`default_nettype none

module lfu_cache_table_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [4:0]  cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // key [31:0], value [63:32]
  input  wire  [0:0]  s_axis_tuser,   // mode [0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // read_value [31:0]
  output logic [0:0]  m_axis_tuser    // hit [0]
);
  import lfu_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MATCH  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_EVICT  = 6'b001000,
    ST_INSERT = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CAP_W-1:0] cap_q;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [IDX_W-1:0] scan_cnt_q, scan_cnt_d;
  logic             mode_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic             res_hit_q, res_hit_d;
  logic [VAL_W-1:0] res_val_q, res_val_d;
  logic             m_valid_q;
  logic             m_hit_q;
  logic [VAL_W-1:0] m_data_q;

  cell_cmd_t         cmd;
  logic [ENTRIES-1:0] sel;
  cand_t             chain [ENTRIES+1];
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] match_vec;
  logic [VAL_W-1:0]   cell_value [ENTRIES];
  logic [RANK_W-1:0]  cell_rank [ENTRIES];

  logic [VAL_W-1:0]   hit_value;
  logic [RANK_W-1:0]  hit_rank;
  logic               hit_any;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] free_sel;
  logic [ENTRIES-1:0] victim_sel;
  logic [CMP_W-1:0]   eff_cap;
  logic [CMP_W-1:0]   occ_ext;
  logic [CMP_W-1:0]   occ_dec_ext;
  logic               need_evict_now;
  logic               need_evict_next;
  logic               out_free;

  assign chain[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .sel_i   (sel[g]),
      .cand_i  (chain[g]),
      .cand_o  (chain[g+1]),
      .valid_o (valid_vec[g]),
      .match_o (match_vec[g]),
      .value_o (cell_value[g]),
      .rank_o  (cell_rank[g])
    );
  end

  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (cell_value[i] & {VAL_W{match_vec[i]}});
      hit_rank  = hit_rank  | (cell_rank[i]  & {RANK_W{match_vec[i]}});
    end
  end

  assign hit_any  = |match_vec;
  assign free_vec = ~valid_vec;
  assign free_sel = free_vec & (~free_vec + 1'b1);

  always_comb begin
    victim_sel = '0;
    victim_sel[chain[ENTRIES].idx] = chain[ENTRIES].found;
  end

  assign eff_cap = (CMP_W'(cap_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_q);
  assign occ_ext     = CMP_W'(occ_q);
  assign occ_dec_ext = occ_ext - 1'b1;
  assign need_evict_now  = (occ_ext >= eff_cap) && (occ_ext != '0);
  assign need_evict_next = (occ_dec_ext >= eff_cap) && (occ_dec_ext != '0);

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    scan_cnt_d   = scan_cnt_q;
    res_hit_d    = res_hit_q;
    res_val_d    = res_val_q;
    cmd.op       = OP_IDLE;
    cmd.wr_value = 1'b0;
    cmd.ref_rank = '0;
    cmd.key      = key_q;
    cmd.value    = value_q;
    sel          = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        res_hit_d = hit_any;
        res_val_d = {VAL_W{1'b1}};
        state_d   = ST_DONE;
        if (!mode_q) begin
          if (hit_any) begin
            res_val_d    = hit_value;
            cmd.op       = OP_TOUCH;
            cmd.ref_rank = hit_rank;
            sel          = match_vec;
          end
        end else if (eff_cap != '0) begin
          if (hit_any) begin
            cmd.op       = OP_TOUCH;
            cmd.wr_value = 1'b1;
            cmd.ref_rank = hit_rank;
            sel          = match_vec;
          end else if (need_evict_now) begin
            scan_cnt_d = '0;
            state_d    = ST_SCAN;
          end else begin
            state_d = ST_INSERT;
          end
        end
      end
      ST_SCAN: begin
        cmd.op     = OP_SCAN;
        scan_cnt_d = scan_cnt_q + 1'b1;
        if (scan_cnt_q == IDX_W'(ENTRIES - 1)) begin
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        cmd.op       = OP_EVICT;
        cmd.ref_rank = chain[ENTRIES].rank;
        sel          = victim_sel;
        if (chain[ENTRIES].found) begin
          occ_d = occ_q - 1'b1;
        end
        scan_cnt_d = '0;
        state_d    = need_evict_next ? ST_SCAN : ST_INSERT;
      end
      ST_INSERT: begin
        cmd.op  = OP_INSERT;
        sel     = free_sel;
        if (|free_sel) begin
          occ_d = occ_q + 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cap_q      <= CAP_W'(CAP_RESET);
      occ_q      <= '0;
      scan_cnt_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      scan_cnt_q <= scan_cnt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if ((state_q == ST_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_hit_q <= res_hit_d;
    res_val_q <= res_val_d;
    if ((state_q == ST_IDLE) && s_axis_tvalid) begin
      mode_q  <= s_axis_tuser[0];
      key_q   <= s_axis_tdata[KEY_W-1:0];
      value_q <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if ((state_q == ST_DONE) && out_free) begin
      m_hit_q  <= res_hit_q;
      m_data_q <= res_val_q;
    end
  end

  assign s_axis_tready   = (state_q == ST_IDLE);
  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_hit_q;

endmodule

`default_nettype wire
